@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: command and status
// codes, the per-cell status record and the broadcast operation record.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_PAYLOAD_BITS = 32;
   localparam int CMD_BITS         = 3;
   localparam int PRIO_BITS        = 8;
   localparam int WORD_BITS        = 32;
   localparam int STATUS_BITS      = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT      = 3'd0,
      CMD_REMOVE_HEAD = 3'd1,
      CMD_REMOVE_EQ   = 3'd2,
      CMD_REMOVE_GE   = 3'd3,
      CMD_CLEAR       = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Operation broadcast to every cell in the cycle of a transfer.
   typedef struct packed {
      logic                 insert;
      logic                 take_all;
      logic                 take_le;
      logic                 clear;
      logic [PRIO_BITS-1:0] prio;
   } op_type;

   // What a cell shows to its neighbors and to the top level.
   typedef struct packed {
      logic                 valid;
      logic                 ge;
      logic                 match;
      logic [PRIO_BITS-1:0] prio;
   } cell_stat_type;

endpackage

@@ rtl/core/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue. Holds a valid bit, a priority and a data word, and
// each cycle keeps its entry, loads the new entry, or takes the entry of its
// left or right neighbor, or clears, as the broadcast operation calls for.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::op_type       op,
   input  logic [PAYLOAD_BITS-1:0] new_data,
   input  spq_pkg::cell_stat_type left_stat,
   input  logic [PAYLOAD_BITS-1:0] left_data,
   input  spq_pkg::cell_stat_type right_stat,
   input  logic [PAYLOAD_BITS-1:0] right_data,
   output spq_pkg::cell_stat_type stat_out,
   output logic [PAYLOAD_BITS-1:0] data_out
);
   import spq_pkg::*;

   logic                    valid_ff, valid_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0] data_ff, data_in;
   logic                    ge;
   logic                    match;
   logic                    le;

   assign ge    = valid_ff && (prio_ff >= op.prio);
   assign match = valid_ff && (prio_ff == op.prio);
   assign le    = valid_ff && (prio_ff <= op.prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      data_in  = data_ff;
      priority if (op.clear) begin
         valid_in = 1'b0;
      end else if (op.insert && !ge) begin
         // first cell below the new priority loads it, the rest move right
         if (left_stat.ge) begin
            valid_in = 1'b1;
            prio_in  = op.prio;
            data_in  = new_data;
         end else begin
            valid_in = left_stat.valid;
            prio_in  = left_stat.prio;
            data_in  = left_data;
         end
      end else if (op.take_all || (op.take_le && le)) begin
         // close the gap: advance the right neighbor's entry
         valid_in = right_stat.valid;
         prio_in  = right_stat.prio;
         data_in  = right_data;
      end else begin
         // hold the entry
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign stat_out.valid = valid_ff;
   assign stat_out.ge    = ge;
   assign stat_out.match = match;
   assign stat_out.prio  = prio_ff;
   assign data_out       = data_ff;

endmodule

@@ rtl/core/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept in falling priority order, first in, first out
// among equal priorities, built as a row of cells that shift in parallel.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   request | req_valid/ready, command, prio_value, payload | in
//   result  | rsp_valid/ready, status, payload_out, prio_out| out
//
// One command per cycle while results are taken: every cell compares its
// entry with the broadcast priority and shifts to or from a neighbor in
// the cycle of the transfer. The result is registered and appears the
// cycle after the transfer. A result waiting on rsp_ready holds req_ready
// low only if it is not taken in the same cycle. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int QUEUE_DEPTH  = spq_pkg::DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [spq_pkg::CMD_BITS-1:0]       req_command,
   input  logic [spq_pkg::PRIO_BITS-1:0]      req_prio_value,
   input  logic [spq_pkg::WORD_BITS-1:0]      req_payload_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spq_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [spq_pkg::WORD_BITS-1:0]      rsp_payload_out,
   output logic [spq_pkg::PRIO_BITS-1:0]      rsp_prio_out
);
   import spq_pkg::*;

   cell_stat_type           cell_stat  [QUEUE_DEPTH];
   cell_stat_type           left_stat  [QUEUE_DEPTH];
   cell_stat_type           right_stat [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_data  [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] left_data  [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] right_data [QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0]  match_vec;
   logic [QUEUE_DEPTH-1:0]  first_vec;
   logic                    any_match;
   logic                    full;
   logic                    head_valid;
   logic                    accept;

   logic [PAYLOAD_BITS-1:0] new_data;
   logic [PAYLOAD_BITS-1:0] sel_data;
   logic [PRIO_BITS-1:0]    sel_prio;
   logic [WORD_BITS-1:0]    head_word;
   logic [WORD_BITS-1:0]    sel_word;
   op_type                  op;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]    rsp_payload_ff, rsp_payload_in;
   logic [PRIO_BITS-1:0]    rsp_prio_ff, rsp_prio_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Fit the external data word to the stored width and back.
   generate
      if (PAYLOAD_BITS > WORD_BITS) begin : g_wide
         assign new_data  = {{(PAYLOAD_BITS-WORD_BITS){1'b0}}, req_payload_in};
         assign head_word = cell_data[0][WORD_BITS-1:0];
         assign sel_word  = sel_data[WORD_BITS-1:0];
      end else if (PAYLOAD_BITS == WORD_BITS) begin : g_same
         assign new_data  = req_payload_in;
         assign head_word = cell_data[0];
         assign sel_word  = sel_data;
      end else begin : g_narrow
         assign new_data  = req_payload_in[PAYLOAD_BITS-1:0];
         assign head_word = {{(WORD_BITS-PAYLOAD_BITS){1'b0}}, cell_data[0]};
         assign sel_word  = {{(WORD_BITS-PAYLOAD_BITS){1'b0}}, sel_data};
      end
   endgenerate

   // Chain of cells with fixed boundary values at both ends.
   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_left_end
            assign left_stat[i] = '{valid: 1'b0, ge: 1'b1, match: 1'b0, prio: '0};
            assign left_data[i] = '0;
         end else begin : g_left_link
            assign left_stat[i] = cell_stat[i-1];
            assign left_data[i] = cell_data[i-1];
         end
         if (i == QUEUE_DEPTH-1) begin : g_right_end
            assign right_stat[i] = '{valid: 1'b0, ge: 1'b0, match: 1'b0, prio: '0};
            assign right_data[i] = '0;
         end else begin : g_right_link
            assign right_stat[i] = cell_stat[i+1];
            assign right_data[i] = cell_data[i+1];
         end
         assign match_vec[i] = cell_stat[i].match;

         spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (op),
            .new_data   (new_data),
            .left_stat  (left_stat[i]),
            .left_data  (left_data[i]),
            .right_stat (right_stat[i]),
            .right_data (right_data[i]),
            .stat_out   (cell_stat[i]),
            .data_out   (cell_data[i])
         );
      end
   endgenerate

   assign full       = cell_stat[QUEUE_DEPTH-1].valid;
   assign head_valid = cell_stat[0].valid;
   assign any_match  = |match_vec;
   // matches are contiguous in a sorted row: the oldest is the leftmost
   assign first_vec  = match_vec & ~{match_vec[QUEUE_DEPTH-2:0], 1'b0};

   always_comb begin
      sel_data = '0;
      sel_prio = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_data = sel_data | (cell_data[i] & {PAYLOAD_BITS{first_vec[i]}});
         sel_prio = sel_prio | (cell_stat[i].prio & {PRIO_BITS{first_vec[i]}});
      end
   end

   // Operation to the cells and the result of this transfer.
   always_comb begin
      op             = '{insert: 1'b0, take_all: 1'b0, take_le: 1'b0, clear: 1'b0,
                         prio: req_prio_value};
      rsp_status_in  = STATUS_NONE;
      rsp_payload_in = '0;
      rsp_prio_in    = '0;
      unique case (cmd_type'(req_command))
         CMD_INSERT: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               op.insert     = accept;
               rsp_status_in = STATUS_DONE;
            end
         end
         CMD_REMOVE_HEAD: begin
            if (head_valid) begin
               op.take_all    = accept;
               rsp_status_in  = STATUS_DONE;
               rsp_payload_in = head_word;
               rsp_prio_in    = cell_stat[0].prio;
            end
         end
         CMD_REMOVE_EQ: begin
            if (any_match) begin
               op.take_le     = accept;
               rsp_status_in  = STATUS_DONE;
               rsp_payload_in = sel_word;
               rsp_prio_in    = sel_prio;
            end
         end
         CMD_REMOVE_GE: begin
            if (cell_stat[0].ge) begin
               op.take_all    = accept;
               rsp_status_in  = STATUS_DONE;
               rsp_payload_in = head_word;
               rsp_prio_in    = cell_stat[0].prio;
            end
         end
         CMD_CLEAR: begin
            op.clear      = accept;
            rsp_status_in = STATUS_DONE;
         end
         default: begin
            rsp_status_in = STATUS_NONE;
         end
      endcase
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_prio_ff    <= rsp_prio_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_prio_out    = rsp_prio_ff;

endmodule
